// ----- design/skp_pkg.sv -----
// Shared types, character constants and keyword tables for the status keyword parser.
`default_nettype none

package skp_pkg;

   // Field widths of the request and response transactions.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;

   // Keyword table geometry.
   localparam int unsigned KW_COUNT   = 4;
   localparam int unsigned KW_MAX_LEN = 9;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned PREFIX_LEN = 6;

   // Characters with a special role in the message grammar.
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_THREE   = 8'h33;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   // Status codes, which are also the keyword indexes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_IDLE      = 2'd0,
      STATUS_WORKING   = 2'd1,
      STATUS_ATTENTION = 2'd2,
      STATUS_URGENT    = 2'd3
   } status_type;

   // Keyword text, right-justified so that the last letter sits in the low byte.
   localparam logic [BYTE_W*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      72'("idle"), 72'("working"), 72'("attention"), 72'("urgent")
   };
   localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd7, 4'd9, 4'd6};
   localparam logic [BYTE_W*PREFIX_LEN-1:0] PREFIX_TEXT = "signal";

   // Request and response payloads.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                parsed_ok;
      logic [STATUS_W-1:0] status_code;
   } rsp_payload_type;

   // Fold an upper-case ASCII letter to lower case; other bytes pass unchanged.
   function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] b);
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         return b + CASE_OFFSET;
      end
      return b;
   endfunction

   // Letter at a position of a status keyword; only meaningful below its length.
   function automatic logic [BYTE_W-1:0] keyword_char(input logic [STATUS_W-1:0] k,
                                                      input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] idx;
      idx = KW_LEN[k] - pos - 4'd1;
      return KW_TEXT[k][{idx, 3'b000} +: BYTE_W];
   endfunction

   // Letter at a position of the optional prefix word.
   function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
      logic [2:0] idx;
      idx = 3'(PREFIX_LEN - 1) - pos;
      return PREFIX_TEXT[{idx, 3'b000} +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

// ----- design/skp_if.sv -----
// Valid/ready channel interfaces for the request and response transactions.
`default_nettype none

interface skp_req_if import skp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   logic              last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface skp_rsp_if import skp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                parsed_ok;
   logic [STATUS_W-1:0] status_code;

   modport source (output valid, output parsed_ok, output status_code, input ready);
   modport sink   (input valid, input parsed_ok, input status_code, output ready);
endinterface

`default_nettype wire

// ----- design/status_keyword_parser_core.sv -----
// Top level of the status keyword parser: input register, parse step and result register.
//
// The parser takes a message one byte per transaction on the request channel, with
// last_byte set on its final byte, and answers with one response transaction per
// message. Leading spaces and tabs are skipped; a body of exactly one byte '0'..'3'
// gives that digit as the status; otherwise an optional case-insensitive "signal"
// prefix and the spaces, tabs and colons after it are skipped, and the rest must
// begin with "idle", "working", "attention" or "urgent" (case-insensitive, trailing
// bytes ignored). A failed parse reports parsed_ok = 0 with status_code = 0. One byte
// is accepted every cycle while the parser does not stall; a byte is held in the input
// register and its parse state update is done as it leaves that register, where a
// final byte also loads the result register that presents the response. The only
// stall comes from a response that has not been taken while another final byte
// waits to be reported.
`default_nettype none

module status_keyword_parser_core import skp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   skp_req_if.sink    req_ch,
   skp_rsp_if.source  rsp_ch
);

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_SIGNAL = 3'd1,
      PH_SEP    = 3'd2,
      PH_WORD   = 3'd3,
      PH_DONE   = 3'd4,
      PH_FAIL   = 3'd5
   } phase_type;

   // Input register.
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // Parse state.
   phase_type           phase_ff, phase_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [STATUS_W-1:0] kw_ff, kw_in;
   logic [1:0]          body_ff, body_in;
   logic [BYTE_W-1:0]   first_ff, first_in;
   logic [STATUS_W-1:0] held_ff, held_in;

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic              advance;
   logic              rsp_free;
   logic [BYTE_W-1:0] low_byte;
   logic              is_blank;
   logic              start_hit;
   logic [STATUS_W-1:0] start_kw;
   logic [POS_W-1:0]  pos_next;

   // The result slot is free when empty or being emptied in this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.parsed_ok   = rsp_ff.parsed_ok;
   assign rsp_ch.status_code = rsp_ff.status_code;

   assign low_byte = lower_byte(in_byte_ff);
   assign is_blank = (in_byte_ff == CHAR_SPACE) || (in_byte_ff == CHAR_TAB);
   assign pos_next = pos_ff + 4'd1;

   // Pick the keyword whose first letter matches the current byte.
   always_comb begin
      start_hit = 1'b0;
      start_kw  = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!start_hit && keyword_char(STATUS_W'(k), '0) == low_byte) begin
            start_hit = 1'b1;
            start_kw  = STATUS_W'(k);
         end
      end
   end

   // One parse step on the byte leaving the input register.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      kw_in    = kw_ff;
      body_in  = body_ff;
      first_in = first_ff;
      held_in  = held_ff;

      if (phase_ff != PH_LEAD && body_ff < 2'd2) begin
         body_in = body_ff + 2'd1;
      end

      case (phase_ff)
         PH_LEAD: begin
            if (!is_blank) begin
               body_in  = 2'd1;
               first_in = in_byte_ff;
               if (low_byte == prefix_char('0)) begin
                  pos_in   = 4'd1;
                  phase_in = PH_SIGNAL;
               end else if (start_hit) begin
                  kw_in    = start_kw;
                  pos_in   = 4'd1;
                  phase_in = PH_WORD;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
         end
         PH_SIGNAL: begin
            if (pos_ff < POS_W'(PREFIX_LEN) && low_byte == prefix_char(pos_ff[2:0])) begin
               pos_in = pos_next;
               if (pos_next >= POS_W'(PREFIX_LEN)) begin
                  phase_in = PH_SEP;
               end
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_SEP: begin
            if (!(is_blank || in_byte_ff == CHAR_COLON)) begin
               if (start_hit) begin
                  kw_in    = start_kw;
                  pos_in   = 4'd1;
                  phase_in = PH_WORD;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
         end
         PH_WORD: begin
            if (pos_ff < KW_LEN[kw_ff] && low_byte == keyword_char(kw_ff, pos_ff)) begin
               pos_in = pos_next;
               if (pos_next >= KW_LEN[kw_ff]) begin
                  held_in  = kw_ff;
                  phase_in = PH_DONE;
               end
            end else begin
               phase_in = PH_FAIL;
            end
         end
         default: begin
            // Done, failed and unused codes hold their state.
         end
      endcase

      // Verdict on the final byte: a lone digit wins over a keyword match.
      if (body_in == 2'd1 && first_in >= CHAR_ZERO && first_in <= CHAR_THREE) begin
         rsp_in.parsed_ok   = 1'b1;
         rsp_in.status_code = first_in[STATUS_W-1:0];
      end else if (phase_in == PH_DONE) begin
         rsp_in.parsed_ok   = 1'b1;
         rsp_in.status_code = held_in;
      end else begin
         rsp_in.parsed_ok   = 1'b0;
         rsp_in.status_code = STATUS_IDLE;
      end
   end

   // Input register takes a transaction whenever it is empty or draining.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.byte_in;
         in_last_ff <= req_ch.last_byte;
      end
   end

   // Parse state; a final byte returns it to the start of a message.
   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         phase_ff <= PH_LEAD;
         pos_ff   <= '0;
         kw_ff    <= '0;
         body_ff  <= '0;
         first_ff <= '0;
         held_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         kw_ff    <= kw_in;
         body_ff  <= body_in;
         first_ff <= first_in;
         held_ff  <= held_in;
      end
   end

   // Result register holds one response until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
